@@ hw/rtl/http_request_head_tokenizer_assert.svh @@
// assertion macros for the request head tokenizer
// sampled on clk, disabled while rst_n is low; no other dependencies
`ifndef HTTP_REQUEST_HEAD_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_TOKENIZER_ASSERT_SVH

`ifndef ASSERT_OFF

`define HRT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrt assertion failed");

`define HRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrt assertion failed");

`else

`define HRT_ASSERT_IMPL(lbl, ante, cons)

`define HRT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ hw/rtl/hrt_pkg.sv @@
// types and constants for the request head tokenizer
// no dependencies
package hrt_pkg;

    localparam int FIELD_W = 13;
    localparam int LIMIT_W = 14;
    localparam int HEAD_LIMIT_RESET = 4096;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    typedef logic [FIELD_W-1:0] field_t;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3f;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CAP_C = 8'h43;
    localparam logic [7:0] CH_LOW_Y = 8'h79;
    localparam logic [7:0] CH_LOW_E = 8'h65;

    localparam int NAME_LEN_CTYPE = 12;
    localparam int NAME_LEN_CLEN  = 14;
    localparam int TENTH_POS      = 9;

    localparam logic [3:0] TK_METHOD   = 4'd0;
    localparam logic [3:0] TK_PATH     = 4'd1;
    localparam logic [3:0] TK_QUERY    = 4'd2;
    localparam logic [3:0] TK_PROTOCOL = 4'd3;
    localparam logic [3:0] TK_HEADER   = 4'd4;
    localparam logic [3:0] TK_CTYPE    = 4'd5;
    localparam logic [3:0] TK_CLEN     = 4'd6;
    localparam logic [3:0] TK_HEAD_END = 4'd7;
    localparam logic [3:0] TK_ERROR    = 4'd8;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_LINE_LF  = 3'd1;
    localparam logic [2:0] ERR_COLON_SP = 3'd2;
    localparam logic [2:0] ERR_HDR_LF   = 3'd3;
    localparam logic [2:0] ERR_FINAL_LF = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG = 3'd5;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       new_request;
    } in_item_t;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [2:0] error_code;
        field_t     first_start;
        field_t     first_end;
        field_t     second_start;
        field_t     second_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       fresh;
        logic       is_space;
        logic       is_qmark;
        logic       is_colon;
        logic       is_cr;
        logic       is_lf;
        logic       is_cap_c;
    } cls_item_t;

endpackage

@@ hw/rtl/hrt_front.sv @@
// front end: classifies each incoming byte for the parser
// depends on hrt_pkg
module hrt_front (
    input  hrt_pkg::in_item_t  item,
    output hrt_pkg::cls_item_t cls
);

    always_comb
    begin
        cls.byte_in  = item.byte_in;
        cls.fresh    = item.new_request;
        cls.is_space = (item.byte_in == hrt_pkg::CH_SPACE);
        cls.is_qmark = (item.byte_in == hrt_pkg::CH_QMARK);
        cls.is_colon = (item.byte_in == hrt_pkg::CH_COLON);
        cls.is_cr    = (item.byte_in == hrt_pkg::CH_CR);
        cls.is_lf    = (item.byte_in == hrt_pkg::CH_LF);
        cls.is_cap_c = (item.byte_in == hrt_pkg::CH_CAP_C);
    end

endmodule

@@ hw/rtl/hrt_queue.sv @@
// short fifo of classified bytes between front and back
// depends on hrt_pkg
module hrt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hrt_pkg::cls_item_t wr_item,
    input  logic               pop,
    output hrt_pkg::cls_item_t rd_item,
    output logic               rd_valid,
    output logic               full
);

    hrt_pkg::cls_item_t             entries_reg [hrt_pkg::Q_DEPTH];
    logic [hrt_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [hrt_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [hrt_pkg::Q_PTR_W:0]      count_reg, count_next;

    assign rd_item  = entries_reg[rd_ptr_reg];
    assign rd_valid = (count_reg != '0);
    assign full     = (count_reg == (hrt_pkg::Q_PTR_W + 1)'(hrt_pkg::Q_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ hw/rtl/hrt_back.sv @@
// back end: request line and header state machine with output register
// depends on hrt_pkg
module hrt_back #(
    parameter int HEAD_BYTES = 8192
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hrt_pkg::LIMIT_W-1:0]  cfg_limit,
    input  hrt_pkg::cls_item_t           item,
    input  logic                         item_valid,
    output logic                         item_pop,
    output hrt_pkg::out_item_t           res_item,
    output logic                         res_valid,
    input  logic                         res_stall
);

    localparam int OFS_W = $clog2(HEAD_BYTES);
    localparam int CMP_W = (OFS_W > hrt_pkg::LIMIT_W) ? OFS_W : hrt_pkg::LIMIT_W;
    localparam logic [CMP_W-1:0] MAX_LIM = CMP_W'(HEAD_BYTES - 1);
    localparam logic [CMP_W-1:0] RST_LIM =
        (HEAD_BYTES - 1 < hrt_pkg::HEAD_LIMIT_RESET) ? MAX_LIM
                                                    : CMP_W'(hrt_pkg::HEAD_LIMIT_RESET);

    typedef logic [OFS_W-1:0] ofs_t;

    typedef enum logic [15:0] {
        PH_IDLE    = 16'b0000_0000_0000_0001,
        PH_METHOD  = 16'b0000_0000_0000_0010,
        PH_SPACE1  = 16'b0000_0000_0000_0100,
        PH_URI     = 16'b0000_0000_0000_1000,
        PH_MARK    = 16'b0000_0000_0001_0000,
        PH_QUERY   = 16'b0000_0000_0010_0000,
        PH_SPACE2  = 16'b0000_0000_0100_0000,
        PH_PROTO   = 16'b0000_0000_1000_0000,
        PH_RL_LF   = 16'b0000_0001_0000_0000,
        PH_H_START = 16'b0000_0010_0000_0000,
        PH_H_NAME  = 16'b0000_0100_0000_0000,
        PH_H_COLON = 16'b0000_1000_0000_0000,
        PH_H_SPACE = 16'b0001_0000_0000_0000,
        PH_H_VALUE = 16'b0010_0000_0000_0000,
        PH_H_LF    = 16'b0100_0000_0000_0000,
        PH_H_DONE  = 16'b1000_0000_0000_0000
    } phase_t;

    phase_t              phase_reg, phase_next;
    ofs_t                offset_reg, offset_next;
    ofs_t                span_reg, span_next;
    ofs_t                name_end_reg, name_end_next;
    ofs_t                value_start_reg, value_start_next;
    logic                first_c_reg, first_c_next;
    logic [7:0]          tenth_reg, tenth_next;
    logic [CMP_W-1:0]    lim_reg, lim_next;
    logic                out_valid_reg, out_valid_next;
    hrt_pkg::out_item_t  out_data_reg;

    logic                take;
    logic                produce;
    hrt_pkg::out_item_t  result;
    ofs_t                o;
    ofs_t                o_inc;
    ofs_t                name_len;
    logic [CMP_W-1:0]    cfg_ext;

    assign take      = item_valid && (!out_valid_reg || !res_stall);
    assign item_pop  = take;
    assign res_valid = out_valid_reg;
    assign res_item  = out_data_reg;

    assign cfg_ext  = CMP_W'(cfg_limit);
    assign lim_next = cfg_we ? ((cfg_ext > MAX_LIM) ? MAX_LIM : cfg_ext) : lim_reg;

    assign o        = item.fresh ? '0 : offset_reg;
    assign o_inc    = o + 1'b1;
    assign name_len = name_end_reg - span_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        offset_next      = offset_reg;
        span_next        = span_reg;
        name_end_next    = name_end_reg;
        value_start_next = value_start_reg;
        first_c_next     = first_c_reg;
        tenth_next       = tenth_reg;
        produce          = 1'b0;
        result           = '0;

        if (take && (item.fresh || phase_reg != PH_IDLE))
        begin
            priority if (CMP_W'(o) >= lim_reg)
            begin
                produce            = 1'b1;
                result.token_kind  = hrt_pkg::TK_ERROR;
                result.error_code  = hrt_pkg::ERR_TOO_LONG;
                result.first_start = hrt_pkg::field_t'(o);
                result.first_end   = hrt_pkg::field_t'(o);
                phase_next         = PH_IDLE;
                offset_next        = o;
            end
            else if (item.fresh)
            begin
                span_next   = '0;
                phase_next  = PH_METHOD;
                offset_next = o_inc;
            end
            else
            begin
                offset_next = o_inc;
                unique case (phase_reg)
                    PH_METHOD:
                    begin
                        if (item.is_space)
                        begin
                            produce            = 1'b1;
                            result.token_kind  = hrt_pkg::TK_METHOD;
                            result.first_start = hrt_pkg::field_t'(span_reg);
                            result.first_end   = hrt_pkg::field_t'(o);
                            phase_next         = PH_SPACE1;
                        end
                    end
                    PH_SPACE1:
                    begin
                        span_next  = o;
                        phase_next = PH_URI;
                    end
                    PH_URI:
                    begin
                        if (item.is_qmark || item.is_space)
                        begin
                            produce            = 1'b1;
                            result.token_kind  = hrt_pkg::TK_PATH;
                            result.first_start = hrt_pkg::field_t'(span_reg);
                            result.first_end   = hrt_pkg::field_t'(o);
                        end
                        if (item.is_qmark)
                        begin
                            phase_next = PH_MARK;
                        end
                        else if (item.is_space)
                        begin
                            value_start_next = o;
                            name_end_next    = o;
                            phase_next       = PH_SPACE2;
                        end
                    end
                    PH_MARK:
                    begin
                        value_start_next = o;
                        if (item.is_space)
                        begin
                            name_end_next = o;
                            phase_next    = PH_SPACE2;
                        end
                        else
                        begin
                            phase_next = PH_QUERY;
                        end
                    end
                    PH_QUERY:
                    begin
                        if (item.is_space)
                        begin
                            name_end_next = o;
                            phase_next    = PH_SPACE2;
                        end
                    end
                    PH_SPACE2:
                    begin
                        produce            = 1'b1;
                        result.token_kind  = hrt_pkg::TK_QUERY;
                        result.first_start = hrt_pkg::field_t'(value_start_reg);
                        result.first_end   = hrt_pkg::field_t'(name_end_reg);
                        span_next          = o;
                        phase_next         = PH_PROTO;
                    end
                    PH_PROTO:
                    begin
                        if (item.is_cr)
                        begin
                            produce            = 1'b1;
                            result.token_kind  = hrt_pkg::TK_PROTOCOL;
                            result.first_start = hrt_pkg::field_t'(span_reg);
                            result.first_end   = hrt_pkg::field_t'(o);
                            phase_next         = PH_RL_LF;
                        end
                    end
                    PH_RL_LF:
                    begin
                        if (!item.is_lf)
                        begin
                            produce            = 1'b1;
                            result.token_kind  = hrt_pkg::TK_ERROR;
                            result.error_code  = hrt_pkg::ERR_LINE_LF;
                            result.first_start = hrt_pkg::field_t'(o);
                            result.first_end   = hrt_pkg::field_t'(o);
                            phase_next         = PH_IDLE;
                            offset_next        = o;
                        end
                        else
                        begin
                            phase_next = PH_H_START;
                        end
                    end
                    PH_H_START:
                    begin
                        if (item.is_cr)
                        begin
                            phase_next = PH_H_DONE;
                        end
                        else
                        begin
                            span_next    = o;
                            first_c_next = item.is_cap_c;
                            tenth_next   = '0;
                            phase_next   = PH_H_NAME;
                        end
                    end
                    PH_H_NAME:
                    begin
                        if (item.is_colon)
                        begin
                            name_end_next = o;
                            phase_next    = PH_H_COLON;
                        end
                        else if (ofs_t'(o - span_reg) == ofs_t'(hrt_pkg::TENTH_POS))
                        begin
                            tenth_next = item.byte_in;
                        end
                    end
                    PH_H_COLON:
                    begin
                        if (!item.is_space)
                        begin
                            produce            = 1'b1;
                            result.token_kind  = hrt_pkg::TK_ERROR;
                            result.error_code  = hrt_pkg::ERR_COLON_SP;
                            result.first_start = hrt_pkg::field_t'(o);
                            result.first_end   = hrt_pkg::field_t'(o);
                            phase_next         = PH_IDLE;
                            offset_next        = o;
                        end
                        else
                        begin
                            phase_next = PH_H_SPACE;
                        end
                    end
                    PH_H_SPACE:
                    begin
                        if (item.is_cr)
                        begin
                            value_start_next = o;
                            phase_next       = PH_H_LF;
                        end
                        else if (!item.is_space)
                        begin
                            value_start_next = o;
                            phase_next       = PH_H_VALUE;
                        end
                    end
                    PH_H_VALUE:
                    begin
                        if (item.is_cr)
                        begin
                            phase_next = PH_H_LF;
                        end
                    end
                    PH_H_LF:
                    begin
                        produce = 1'b1;
                        if (!item.is_lf)
                        begin
                            result.token_kind  = hrt_pkg::TK_ERROR;
                            result.error_code  = hrt_pkg::ERR_HDR_LF;
                            result.first_start = hrt_pkg::field_t'(o);
                            result.first_end   = hrt_pkg::field_t'(o);
                            phase_next         = PH_IDLE;
                            offset_next        = o;
                        end
                        else
                        begin
                            result.token_kind = hrt_pkg::TK_HEADER;
                            if (first_c_reg && name_len == ofs_t'(hrt_pkg::NAME_LEN_CTYPE)
                                && tenth_reg == hrt_pkg::CH_LOW_Y)
                            begin
                                result.token_kind = hrt_pkg::TK_CTYPE;
                            end
                            else if (first_c_reg && name_len == ofs_t'(hrt_pkg::NAME_LEN_CLEN)
                                     && tenth_reg == hrt_pkg::CH_LOW_E)
                            begin
                                result.token_kind = hrt_pkg::TK_CLEN;
                            end
                            result.first_start  = hrt_pkg::field_t'(span_reg);
                            result.first_end    = hrt_pkg::field_t'(name_end_reg);
                            result.second_start = hrt_pkg::field_t'(value_start_reg);
                            result.second_end   = hrt_pkg::field_t'(o - 1'b1);
                            phase_next          = PH_H_START;
                        end
                    end
                    PH_H_DONE:
                    begin
                        produce = 1'b1;
                        if (!item.is_lf)
                        begin
                            result.token_kind  = hrt_pkg::TK_ERROR;
                            result.error_code  = hrt_pkg::ERR_FINAL_LF;
                            result.first_start = hrt_pkg::field_t'(o);
                            result.first_end   = hrt_pkg::field_t'(o);
                            offset_next        = o;
                        end
                        else
                        begin
                            result.token_kind = hrt_pkg::TK_HEAD_END;
                            result.first_end  = hrt_pkg::field_t'(o_inc);
                        end
                        phase_next = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = produce;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            offset_reg      <= '0;
            span_reg        <= '0;
            name_end_reg    <= '0;
            value_start_reg <= '0;
            first_c_reg     <= 1'b0;
            tenth_reg       <= '0;
            lim_reg         <= RST_LIM;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            offset_reg      <= offset_next;
            span_reg        <= span_next;
            name_end_reg    <= name_end_next;
            value_start_reg <= value_start_next;
            first_c_reg     <= first_c_next;
            tenth_reg       <= tenth_next;
            lim_reg         <= lim_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && produce)
        begin
            out_data_reg <= result;
        end
    end

endmodule

@@ hw/rtl/http_request_head_tokenizer.sv @@
// request head tokenizer top level: front classifier, byte queue, parser back end
// path: each byte is registered in the byte queue, then its result in the back end output register
// throughput: one byte per cycle while out_stall is low, set by the single-byte parser state machine
// in_stall rises only when the four-entry byte queue is full
// reset (rst_n low, asynchronous) empties queue and output, sets head limit to 4096
// depends on hrt_pkg, hrt_front, hrt_queue, hrt_back and the assertion header
`include "http_request_head_tokenizer_assert.svh"

module http_request_head_tokenizer #(
    parameter int HEAD_BYTES = 8192
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  hrt_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output hrt_pkg::out_item_t           out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hrt_pkg::LIMIT_W-1:0]  cfg_data
);

    hrt_pkg::cls_item_t cls;
    hrt_pkg::cls_item_t q_item;
    logic               q_valid;
    logic               q_full;
    logic               q_pop;
    logic               push;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;

    hrt_front u_front (
        .item (in_data),
        .cls  (cls)
    );

    hrt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (cls),
        .pop      (q_pop),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .full     (q_full)
    );

    hrt_back #(
        .HEAD_BYTES (HEAD_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_limit  (cfg_data),
        .item       (q_item),
        .item_valid (q_valid),
        .item_pop   (q_pop),
        .res_item   (out_data),
        .res_valid  (out_valid),
        .res_stall  (out_stall)
    );

    `HRT_ASSERT_IMPL(a_error_has_code,
        out_valid && out_data.token_kind == hrt_pkg::TK_ERROR,
        out_data.error_code != hrt_pkg::ERR_NONE)

    `HRT_ASSERT_IMPL(a_token_no_code,
        out_valid && out_data.token_kind != hrt_pkg::TK_ERROR,
        out_data.error_code == hrt_pkg::ERR_NONE)

    `HRT_ASSERT_IMPL(a_value_only_for_header,
        out_valid && out_data.token_kind != hrt_pkg::TK_HEADER
            && out_data.token_kind != hrt_pkg::TK_CTYPE
            && out_data.token_kind != hrt_pkg::TK_CLEN,
        out_data.second_start == '0 && out_data.second_end == '0)

    `HRT_ASSERT_NEXT(a_full_queue_stalls, q_valid && q_full && !q_pop, in_stall)

endmodule
